@@ hw/rtl/saes_pkg.sv @@
package saes_pkg;

	// Round constants used by the key schedule.
	localparam logic [7:0] RCON_1 = 8'h80;
	localparam logic [7:0] RCON_2 = 8'h30;

	// Field polynomial x^4 + x + 1.
	localparam logic [4:0] GF_POLY = 5'b10011;

	// Nibbles that stay in place under the row shift.
	localparam logic [15:0] ROW_KEEP_MASK = 16'hF0F0;

	// Mix matrix coefficients: forward [[1,4],[4,1]], inverse [[9,2],[2,9]].
	localparam logic [3:0] MIX_FWD_D = 4'h1;
	localparam logic [3:0] MIX_FWD_O = 4'h4;
	localparam logic [3:0] MIX_INV_D = 4'b1001;
	localparam logic [3:0] MIX_INV_O = 4'b0010;

	// Cipher direction carried in the mode field.
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	localparam logic [3:0] SBOX_FWD [16] = '{
		4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
		4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
	};
	localparam logic [3:0] SBOX_INV [16] = '{
		4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
		4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
	};

	// The three round keys derived from the cipher key.
	typedef struct packed {
		logic [15:0] k1;
		logic [15:0] k2;
		logic [15:0] k3;
	} saes_rkeys_t;

	// Forward S-box applied to all four nibbles.
	function automatic logic [15:0] sub_nib_fwd(input logic [15:0] v);
		return {SBOX_FWD[v[15:12]], SBOX_FWD[v[11:8]], SBOX_FWD[v[7:4]], SBOX_FWD[v[3:0]]};
	endfunction

	// Inverse S-box applied to all four nibbles.
	function automatic logic [15:0] sub_nib_inv(input logic [15:0] v);
		return {SBOX_INV[v[15:12]], SBOX_INV[v[11:8]], SBOX_INV[v[7:4]], SBOX_INV[v[3:0]]};
	endfunction

	// Swap nibbles 0 and 2; the row shift is its own inverse.
	function automatic logic [15:0] shift_row(input logic [15:0] v);
		return (v & ROW_KEEP_MASK) | {4'h0, v[3:0], 4'h0, v[11:8]};
	endfunction

	// Nibble product in GF(2^4) modulo x^4 + x + 1.
	function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
		logic [6:0] p;
		logic [6:0] poly;
		p = '0;
		poly = {2'b00, GF_POLY};
		for (int i = 0; i < 4; i++) begin
			if (b[i]) begin
				p = p ^ ({3'b000, a} << i);
			end
		end
		for (int i = 6; i >= 4; i--) begin
			if (p[i]) begin
				p = p ^ (poly << (i - 4));
			end
		end
		return p[3:0];
	endfunction

	// Multiply each column by the symmetric matrix [[d,o],[o,d]].
	function automatic logic [15:0] mix_cols(input logic [15:0] v, input logic [3:0] d,
			input logic [3:0] o);
		return {gf_mul(d, v[15:12]) ^ gf_mul(o, v[11:8]),
			gf_mul(o, v[15:12]) ^ gf_mul(d, v[11:8]),
			gf_mul(d, v[7:4]) ^ gf_mul(o, v[3:0]),
			gf_mul(o, v[7:4]) ^ gf_mul(d, v[3:0])};
	endfunction

	// Swap the nibbles of a key byte, then substitute both.
	function automatic logic [7:0] rot_sub_byte(input logic [7:0] b);
		return {SBOX_FWD[b[3:0]], SBOX_FWD[b[7:4]]};
	endfunction

endpackage

@@ hw/rtl/saes_if.sv @@
// Input channel: one block to encrypt or decrypt per transaction.
interface saes_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] block_in;

	modport source (output valid, output mode, output block_in, input ready);
	modport sink (input valid, input mode, input block_in, output ready);
endinterface

// Output channel: one result block per transaction.
interface saes_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] block_out;

	modport source (output valid, output block_out, input ready);
	modport sink (input valid, input block_out, output ready);
endinterface

// Configuration channel: writes the cipher key.
interface saes_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] cipher_key;

	modport source (output valid, output cipher_key, input ready);
	modport sink (input valid, input cipher_key, output ready);
endinterface

@@ hw/rtl/saes_key_exp.sv @@
module saes_key_exp
	import saes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	saes_cfg_if.sink    cfg,
	output saes_rkeys_t rkeys
);

	logic [15:0] key_q;
	logic [7:0]  w0, w1, w2, w3, w4, w5;
	saes_rkeys_t rkeys_d;
	saes_rkeys_t rkeys_q;

	// The key register accepts a write in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg.valid) begin
			key_q <= cfg.cipher_key;
		end
	end

	// Two rounds of the key schedule.
	always_comb begin
		w0 = key_q[15:8];
		w1 = key_q[7:0];
		w2 = w0 ^ RCON_1 ^ rot_sub_byte(w1);
		w3 = w2 ^ w1;
		w4 = w2 ^ RCON_2 ^ rot_sub_byte(w3);
		w5 = w4 ^ w3;
		rkeys_d.k1 = {w0, w1};
		rkeys_d.k2 = {w2, w3};
		rkeys_d.k3 = {w4, w5};
	end

	// Round keys are registered, so the schedule stays off the cipher path.
	always_ff @(posedge clk) begin
		rkeys_q <= rkeys_d;
	end

	assign rkeys = rkeys_q;

endmodule

@@ hw/rtl/simplified_aes_cipher.sv @@
// Simplified AES (S-AES) on 16-bit blocks. The cipher key is written through
// the cfg channel into a key register and the three round keys are expanded
// from it into round-key registers; write the key only while no block is in
// flight. Each din transaction carries a mode (0 encrypt, 1 decrypt) and a
// block, and yields exactly one dout transaction, in order. A block is taken
// into an input register, both cipher rounds are evaluated in combinational
// logic, and the result lands in an output register; a new block is accepted
// every cycle while results are taken. A waiting result stops the next block
// from entering the input register only when that register is also full.
module simplified_aes_cipher
	import saes_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	saes_cfg_if.sink  cfg,
	saes_in_if.sink   din,
	saes_out_if.source dout
);

	saes_rkeys_t rkeys;

	logic        valid_s1;
	logic        mode_s1;
	logic [15:0] block_s1;
	logic        valid_s2;
	logic [15:0] block_s2;
	logic        adv_s1;
	logic [15:0] enc_a, enc_b, enc_c;
	logic [15:0] dec_a, dec_b, dec_c;
	logic [15:0] result;

	saes_key_exp u_key_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rkeys  (rkeys)
	);

	// Stage one moves on when the output register is empty or being drained.
	assign adv_s1   = !valid_s2 || dout.ready;
	assign din.ready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			mode_s1  <= din.mode;
			block_s1 <= din.block_in;
		end
	end

	// Both rounds in each direction, then select by mode.
	always_comb begin
		enc_a = shift_row(sub_nib_fwd(block_s1 ^ rkeys.k1));
		enc_b = mix_cols(enc_a, MIX_FWD_D, MIX_FWD_O) ^ rkeys.k2;
		enc_c = shift_row(sub_nib_fwd(enc_b)) ^ rkeys.k3;

		dec_a = sub_nib_inv(shift_row(block_s1 ^ rkeys.k3)) ^ rkeys.k2;
		dec_b = mix_cols(dec_a, MIX_INV_D, MIX_INV_O);
		dec_c = sub_nib_inv(shift_row(dec_b)) ^ rkeys.k1;

		result = (mode_s1 == MODE_DECRYPT) ? dec_c : enc_c;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			block_s2 <= result;
		end
	end

	assign dout.valid     = valid_s2;
	assign dout.block_out = block_s2;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	import saes_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_BLOCKS = 130;
	localparam int VECTOR_PHASE_BLOCKS = 100;
	localparam int RANDOM_KEY_PHASES = 5;
	localparam int HOLD_PHASE = 3;

	// Own copies of the substitution tables used by the predictor.
	localparam logic [3:0] FWD_BOX [16] = '{
		4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
		4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
	};
	localparam logic [3:0] INV_BOX [16] = '{
		4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
		4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
	};

	localparam logic [15:0] EDGE_BLOCKS [8] = '{
		16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0
	};
	localparam logic [15:0] EDGE_KEYS [6] = '{
		16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h00FF, 16'hFF00
	};

	// Published worked example: this plaintext encrypts to this ciphertext.
	localparam logic [15:0] VECTOR_KEY = 16'hA73B;
	localparam logic [15:0] VECTOR_PLAIN = 16'h6F6B;
	localparam logic [15:0] VECTOR_CIPHER = 16'h0738;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_PATTERN
	} rx_style_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] blk;
	} block_req_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] blk;
		logic [15:0] result;
	} cipher_exp_t;

	logic clk;
	logic arst_n;

	saes_cfg_if cfg_ch();
	saes_in_if  din_ch();
	saes_out_if dout_ch();

	simplified_aes_cipher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	block_req_t  pending_blocks [$];
	cipher_exp_t expected_blocks [$];
	logic [15:0] active_key;
	int          mismatches;
	int          idle_cycles;
	int          burst_left;
	int          gap_left;
	block_req_t  next_req;
	logic        hold_request;
	logic        hold_done;
	int          hold_left;
	int          style_left;
	rx_style_t   rx_style;
	logic [7:0]  rx_pattern;
	int          pattern_idx;

	// Apply the forward or inverse S-box to every nibble.
	function automatic logic [15:0] nib_sub(input logic [15:0] v, input logic dir);
		logic [15:0] r;
		for (int i = 0; i < 4; i++) begin
			r[4*i +: 4] = (dir == MODE_ENCRYPT) ? FWD_BOX[v[4*i +: 4]] : INV_BOX[v[4*i +: 4]];
		end
		return r;
	endfunction

	// Exchange the two lower-row nibbles of the state.
	function automatic logic [15:0] row_swap(input logic [15:0] v);
		return {v[15:12], v[3:0], v[7:4], v[11:8]};
	endfunction

	// GF(2^4) product by repeated doubling; x^4 reduces to x + 1.
	function automatic logic [3:0] gf_times(input logic [3:0] a, input logic [3:0] b);
		logic [3:0] acc;
		logic [3:0] x;
		acc = 4'h0;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
		end
		return acc;
	endfunction

	// Multiply each byte-wide column by the matrix [[d,o],[o,d]].
	function automatic logic [15:0] col_mix(input logic [15:0] v, input logic [3:0] d,
			input logic [3:0] o);
		logic [15:0] r;
		logic [3:0]  hi;
		logic [3:0]  lo;
		for (int c = 0; c < 2; c++) begin
			hi = v[8*c+4 +: 4];
			lo = v[8*c +: 4];
			r[8*c+4 +: 4] = gf_times(d, hi) ^ gf_times(o, lo);
			r[8*c +: 4] = gf_times(o, hi) ^ gf_times(d, lo);
		end
		return r;
	endfunction

	// Full cipher: key expansion followed by both rounds in either direction.
	function automatic logic [15:0] saes_predict(input logic [15:0] key, input logic dir,
			input logic [15:0] blk);
		logic [7:0]  w2;
		logic [7:0]  w3;
		logic [7:0]  w4;
		logic [7:0]  w5;
		logic [15:0] k2;
		logic [15:0] k3;
		logic [15:0] s;
		w2 = key[15:8] ^ RCON_1 ^ {FWD_BOX[key[3:0]], FWD_BOX[key[7:4]]};
		w3 = w2 ^ key[7:0];
		w4 = w2 ^ RCON_2 ^ {FWD_BOX[w3[3:0]], FWD_BOX[w3[7:4]]};
		w5 = w4 ^ w3;
		k2 = {w2, w3};
		k3 = {w4, w5};
		if (dir == MODE_ENCRYPT) begin
			s = row_swap(nib_sub(blk ^ key, MODE_ENCRYPT));
			s = col_mix(s, MIX_FWD_D, MIX_FWD_O) ^ k2;
			s = row_swap(nib_sub(s, MODE_ENCRYPT)) ^ k3;
		end else begin
			s = nib_sub(row_swap(blk ^ k3), MODE_DECRYPT) ^ k2;
			s = col_mix(s, MIX_INV_D, MIX_INV_O);
			s = nib_sub(row_swap(s), MODE_DECRYPT) ^ key;
		end
		return s;
	endfunction

	// Random blocks, a good share of them as encrypt-then-decrypt round trips.
	task automatic queue_random_blocks(input logic [15:0] key, input int count);
		block_req_t req;
		int         queued;
		queued = 0;
		while (queued < count) begin
			req.blk = 16'($urandom);
			if ($urandom_range(0, 15) == 0) begin
				req.blk = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			if ($urandom_range(0, 9) < 4) begin
				req.mode = MODE_ENCRYPT;
				pending_blocks.push_back(req);
				req.mode = MODE_DECRYPT;
				req.blk = saes_predict(key, MODE_ENCRYPT, req.blk);
				pending_blocks.push_back(req);
				queued += 2;
			end else begin
				req.mode = $urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT;
				pending_blocks.push_back(req);
				queued++;
			end
		end
	endtask

	// Wait until every block has come back, then let the pipeline settle.
	task automatic wait_idle();
		while (pending_blocks.size() != 0 || din_ch.valid || expected_blocks.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the cipher key through the configuration channel.
	task automatic load_key(input logic [15:0] key);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.cipher_key <= key;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		active_key = key;
		@(negedge clk);
	endtask

	// Free-running clock, period 20.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Sender: offers queued blocks in bursts with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_ch.valid <= 1'b0;
			din_ch.mode <= MODE_ENCRYPT;
			din_ch.block_in <= 16'h0000;
			burst_left = 0;
			gap_left = 0;
		end else if (!din_ch.valid || din_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				din_ch.valid <= 1'b0;
			end else if (pending_blocks.size() > 0) begin
				next_req = pending_blocks.pop_front();
				din_ch.valid <= 1'b1;
				din_ch.mode <= next_req.mode;
				din_ch.block_in <= next_req.blk;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				if (burst_left == 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				din_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: switches between stall styles, with one long hold on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_ch.ready <= 1'b0;
			hold_done = 1'b0;
			hold_left = 0;
			style_left = 0;
			rx_style = RX_FREE;
			rx_pattern = 8'hFF;
			pattern_idx = 0;
		end else begin
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (style_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(16, 128);
				rx_pattern = 8'($urandom) | 8'h01;
			end
			style_left--;
			pattern_idx = (pattern_idx + 1) % 8;
			if (hold_left > 0) begin
				hold_left--;
				dout_ch.ready <= 1'b0;
			end else begin
				case (rx_style)
					RX_FREE: begin
						dout_ch.ready <= 1'b1;
					end
					RX_COIN: begin
						dout_ch.ready <= 1'($urandom_range(0, 1));
					end
					RX_SPARSE: begin
						dout_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						dout_ch.ready <= rx_pattern[pattern_idx];
					end
				endcase
			end
		end
	end

	// Monitor: checks each result transaction, then records the expectation for
	// each input transaction.
	always @(posedge clk) begin
		cipher_exp_t want;
		if (arst_n) begin
			if (dout_ch.valid && dout_ch.ready) begin
				if (expected_blocks.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected result: block_out %h with nothing pending",
							dout_ch.block_out);
					end
				end else begin
					want = expected_blocks.pop_front();
					if (dout_ch.block_out !== want.result) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("mismatch: mode %0d block_in %h key %h: block_out expected %h, got %h",
								want.mode, want.blk, active_key, want.result, dout_ch.block_out);
						end
					end
				end
			end
			if (din_ch.valid && din_ch.ready) begin
				want.mode = din_ch.mode;
				want.blk = din_ch.block_in;
				want.result = saes_predict(active_key, din_ch.mode, din_ch.block_in);
				expected_blocks.push_back(want);
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus: reset, directed blocks, then phases of random blocks under many keys.
	initial begin
		block_req_t  req;
		logic [15:0] phase_key;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.cipher_key = 16'h0000;
		active_key = 16'h0000;
		mismatches = 0;
		idle_cycles = 0;
		hold_request = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Edge blocks in both directions under the key left by reset.
		for (int i = 0; i < 8; i++) begin
			req.blk = EDGE_BLOCKS[i];
			req.mode = MODE_ENCRYPT;
			pending_blocks.push_back(req);
			req.mode = MODE_DECRYPT;
			pending_blocks.push_back(req);
		end
		wait_idle();

		// Known worked example, then random traffic under the same key.
		load_key(VECTOR_KEY);
		req.mode = MODE_ENCRYPT;
		req.blk = VECTOR_PLAIN;
		pending_blocks.push_back(req);
		req.mode = MODE_DECRYPT;
		req.blk = VECTOR_CIPHER;
		pending_blocks.push_back(req);
		queue_random_blocks(VECTOR_KEY, VECTOR_PHASE_BLOCKS);
		wait_idle();

		// Extreme keys first, then random ones; one phase holds the receiver off.
		for (int p = 0; p < 6 + RANDOM_KEY_PHASES; p++) begin
			phase_key = (p < 6) ? EDGE_KEYS[p] : 16'($urandom);
			load_key(phase_key);
			queue_random_blocks(phase_key, PHASE_BLOCKS);
			if (p == HOLD_PHASE) begin
				hold_request = 1'b1;
			end
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
